// ===== src/fmr_pkg.sv =====
// Shared widths and types for the fraction multiply and reduce block.
package fmr_pkg;

  // Significant bits taken from each input field; the top one is the sign
  localparam int unsigned OPERAND_WIDTH = 32;
  localparam int unsigned FIELD_WIDTH   = 32;
  localparam int unsigned RES_WIDTH     = 64;
  localparam int unsigned PROD_WIDTH    = 2 * OPERAND_WIDTH;
  localparam int unsigned SHIFT_WIDTH   = $clog2(RES_WIDTH);

  // Status of the shared subtractor
  typedef struct packed {
    logic ge;  // opa >= opb, unsigned
    logic eq;  // opa == opb
  } alu_flags_t;

endpackage

// ===== src/fmr_alu.sv =====
// Shared 64-bit subtract and compare unit used by both gcd and division steps.
module fmr_alu import fmr_pkg::*; (
  input  logic [RES_WIDTH-1:0] opa_i,
  input  logic [RES_WIDTH-1:0] opb_i,
  output logic [RES_WIDTH-1:0] diff_o,
  output alu_flags_t           flags_o
);

  logic [RES_WIDTH:0] sub;

  // Subtract with one extra bit so the borrow gives the compare
  assign sub           = {1'b0, opa_i} - {1'b0, opb_i};
  assign diff_o        = sub[RES_WIDTH-1:0];
  assign flags_o.ge    = ~sub[RES_WIDTH];
  assign flags_o.eq    = (opa_i == opb_i);

endmodule

// ===== src/fraction_multiply_reduce.sv =====
// Fraction multiply with gcd reduction: products, binary gcd, two restoring divisions.
// Steps: numerator product, then denominator product, then a zero check, then one binary gcd
// step per cycle, then restoring division of the numerator and then the denominator by the gcd,
// then the result word is held until taken; a zero product skips to the result word unreduced.
// Throughput: one word at a time; input stall is high from accept until the result word leaves.
// The gcd and division steps share one 64-bit subtractor. Reset returns the sequencer to idle.
module fraction_multiply_reduce import fmr_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [FIELD_WIDTH-1:0] a_num_i,
  input  logic signed [FIELD_WIDTH-1:0] a_den_i,
  input  logic signed [FIELD_WIDTH-1:0] b_num_i,
  input  logic signed [FIELD_WIDTH-1:0] b_den_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [RES_WIDTH-1:0]   res_num_o,
  output logic signed [RES_WIDTH-1:0]   res_den_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MULN = 3'd1;
  localparam logic [2:0] S_MULD = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_GCD  = 3'd4;
  localparam logic [2:0] S_DIVN = 3'd5;
  localparam logic [2:0] S_DIVD = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  // Magnitude of the low operand bits, read as two's complement
  function automatic logic [OPERAND_WIDTH-1:0] mag_of(input logic [FIELD_WIDTH-1:0] raw);
    logic [OPERAND_WIDTH-1:0] v;
    v = raw[OPERAND_WIDTH-1:0];
    return v[OPERAND_WIDTH-1] ? (~v) + OPERAND_WIDTH'(1) : v;
  endfunction

  logic [2:0]               state_q, state_d;
  logic [OPERAND_WIDTH-1:0] an_q, an_d, bn_q, bn_d, ad_q, ad_d, bd_q, bd_d;
  logic                     neg_n_q, neg_n_d, neg_d_q, neg_d_d;
  logic [RES_WIDTH-1:0]     pn_q, pn_d, pd_q, pd_d;
  logic [RES_WIDTH-1:0]     a_q, a_d, b_q, b_d, g_q, g_d;
  logic [RES_WIDTH-1:0]     dv_q, dv_d, rem_q, rem_d;
  logic [SHIFT_WIDTH-1:0]   k_q, k_d, cnt_q, cnt_d;

  logic [OPERAND_WIDTH-1:0] mul_a, mul_b;
  logic [PROD_WIDTH-1:0]    mul_p;
  logic [RES_WIDTH-1:0]     alu_a, alu_b, alu_diff;
  alu_flags_t               alu_flags;
  logic [RES_WIDTH-1:0]     quot;

  // Shared multiplier: numerators first, then denominators
  assign mul_a = (state_q == S_MULD) ? ad_q : an_q;
  assign mul_b = (state_q == S_MULD) ? bd_q : bn_q;
  assign mul_p = PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);

  // Route the subtractor: gcd pair, or shifted remainder against the gcd
  always_comb begin
    if (state_q == S_DIVN || state_q == S_DIVD) begin
      alu_a = {rem_q[RES_WIDTH-2:0], dv_q[RES_WIDTH-1]};
      alu_b = g_q;
    end else begin
      alu_a = a_q;
      alu_b = b_q;
    end
  end

  fmr_alu u_alu (
    .opa_i   (alu_a),
    .opb_i   (alu_b),
    .diff_o  (alu_diff),
    .flags_o (alu_flags)
  );

  assign quot = {dv_q[RES_WIDTH-2:0], alu_flags.ge};

  // Sequencer
  always_comb begin
    state_d = state_q;
    an_d    = an_q;
    bn_d    = bn_q;
    ad_d    = ad_q;
    bd_d    = bd_q;
    neg_n_d = neg_n_q;
    neg_d_d = neg_d_q;
    pn_d    = pn_q;
    pd_d    = pd_q;
    a_d     = a_q;
    b_d     = b_q;
    g_d     = g_q;
    dv_d    = dv_q;
    rem_d   = rem_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          an_d    = mag_of(a_num_i);
          ad_d    = mag_of(a_den_i);
          bn_d    = mag_of(b_num_i);
          bd_d    = mag_of(b_den_i);
          neg_n_d = a_num_i[OPERAND_WIDTH-1] ^ b_num_i[OPERAND_WIDTH-1];
          neg_d_d = a_den_i[OPERAND_WIDTH-1] ^ b_den_i[OPERAND_WIDTH-1];
          state_d = S_MULN;
        end
      end
      S_MULN: begin
        pn_d    = RES_WIDTH'(mul_p);
        state_d = S_MULD;
      end
      S_MULD: begin
        pd_d    = RES_WIDTH'(mul_p);
        state_d = S_CHK;
      end
      S_CHK: begin
        // Pass zero products on unreduced
        if (pn_q == '0 || pd_q == '0) begin
          state_d = S_OUT;
        end else begin
          a_d     = pn_q;
          b_d     = pd_q;
          k_d     = '0;
          state_d = S_GCD;
        end
      end
      S_GCD: begin
        // One binary gcd step per cycle
        if (alu_flags.eq) begin
          g_d     = a_q << k_q;
          dv_d    = pn_q;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = S_DIVN;
        end else if (!a_q[0] && !b_q[0]) begin
          a_d = a_q >> 1;
          b_d = b_q >> 1;
          k_d = k_q + SHIFT_WIDTH'(1);
        end else if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (alu_flags.ge) begin
          a_d = alu_diff;
        end else begin
          a_d = b_q;
          b_d = a_q;
        end
      end
      S_DIVN, S_DIVD: begin
        // Restoring division, one quotient bit per cycle
        rem_d = alu_flags.ge ? alu_diff : alu_a;
        dv_d  = quot;
        cnt_d = cnt_q + SHIFT_WIDTH'(1);
        if (cnt_q == '1) begin
          if (state_q == S_DIVN) begin
            pn_d    = quot;
            dv_d    = pd_q;
            rem_d   = '0;
            state_d = S_DIVD;
          end else begin
            pd_d    = quot;
            state_d = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      cnt_q   <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    an_q    <= an_d;
    bn_q    <= bn_d;
    ad_q    <= ad_d;
    bd_q    <= bd_d;
    neg_n_q <= neg_n_d;
    neg_d_q <= neg_d_d;
    pn_q    <= pn_d;
    pd_q    <= pd_d;
    a_q     <= a_d;
    b_q     <= b_d;
    g_q     <= g_d;
    dv_q    <= dv_d;
    rem_q   <= rem_d;
  end

  // Handshake and result word with signs restored
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign res_num_o   = neg_n_q ? ('0 - pn_q) : pn_q;
  assign res_den_o   = neg_d_q ? ('0 - pd_q) : pd_q;

endmodule
